// ===== hw/rtl/oaat_pkg.sv =====
// ----------------------------------------------------------------------------
// oaat_pkg
// Shared widths, constants and reset values for the one-at-a-time bucket hash.
// ----------------------------------------------------------------------------
package oaat_pkg;

	localparam int HASH_W      = 64;
	localparam int BYTE_W      = 8;
	localparam int COUNT_W     = 32;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEP_W  = $clog2(HASH_W);

	localparam logic [COUNT_W-1:0] BUCKET_COUNT_RESET = 32'd128;

	localparam int MIX_ADD_SHIFT = 10;
	localparam int MIX_XOR_SHIFT = 6;
	localparam int FIN_ADD1_SHIFT = 3;
	localparam int FIN_XOR_SHIFT  = 11;
	localparam int FIN_ADD2_SHIFT = 15;

	localparam logic [APB_ADDR_W-1:0] REG_BUCKET_COUNT = 3'd0;

	typedef logic [HASH_W-1:0] hash_t;

endpackage

// ===== hw/rtl/oaat_front.sv =====
// ----------------------------------------------------------------------------
// oaat_front
// Absorbs key bytes into the running hash and finalises it on the last byte.
// ----------------------------------------------------------------------------
module oaat_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [oaat_pkg::BYTE_W-1:0]   key_byte,
	input  logic                          last_byte,
	output logic                          push_valid,
	input  logic                          push_ready,
	output oaat_pkg::hash_t               push_data
);

	typedef enum logic [1:0] {
		ST_ABSORB,
		ST_FIN1,
		ST_FIN2,
		ST_PUSH
	} state_t;

	state_t          state_q;
	oaat_pkg::hash_t hash_q;
	oaat_pkg::hash_t sum;
	oaat_pkg::hash_t mix_add;
	oaat_pkg::hash_t mix_out;
	oaat_pkg::hash_t fin_add;
	oaat_pkg::hash_t fin1_out;
	oaat_pkg::hash_t fin2_out;

	always_comb begin
		sum      = hash_q + {{(oaat_pkg::HASH_W-oaat_pkg::BYTE_W){key_byte[oaat_pkg::BYTE_W-1]}},
			key_byte};
		mix_add  = sum + (sum << oaat_pkg::MIX_ADD_SHIFT);
		mix_out  = mix_add ^ (mix_add >> oaat_pkg::MIX_XOR_SHIFT);
		fin_add  = hash_q + (hash_q << oaat_pkg::FIN_ADD1_SHIFT);
		fin1_out = fin_add ^ (fin_add >> oaat_pkg::FIN_XOR_SHIFT);
		fin2_out = hash_q + (hash_q << oaat_pkg::FIN_ADD2_SHIFT);
	end

	assign in_ready   = (state_q == ST_ABSORB);
	assign push_valid = (state_q == ST_PUSH);
	assign push_data  = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ABSORB;
			hash_q  <= '0;
		end else begin
			case (state_q)
				ST_ABSORB: begin
					if (in_valid) begin
						hash_q <= mix_out;
						if (last_byte) begin
							state_q <= ST_FIN1;
						end
					end
				end
				ST_FIN1: begin
					hash_q  <= fin1_out;
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					hash_q  <= fin2_out;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (push_ready) begin
						hash_q  <= '0;
						state_q <= ST_ABSORB;
					end
				end
				default: begin
					state_q <= ST_ABSORB;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/oaat_queue.sv =====
// ----------------------------------------------------------------------------
// oaat_queue
// Small first-in first-out queue of finalised hashes between front and back.
// ----------------------------------------------------------------------------
module oaat_queue #(
	parameter int DEPTH = oaat_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  oaat_pkg::hash_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output oaat_pkg::hash_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	oaat_pkg::hash_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/oaat_back.sv =====
// ----------------------------------------------------------------------------
// oaat_back
// Reduces each finalised hash modulo the bucket count (giving zero for a zero
// count), one bit per cycle, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module oaat_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  oaat_pkg::hash_t                pop_data,
	input  logic [oaat_pkg::COUNT_W-1:0]   bucket_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [oaat_pkg::COUNT_W-1:0]   bucket_index,
	output oaat_pkg::hash_t                full_hash
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam logic [oaat_pkg::DIV_STEP_W-1:0] LAST_STEP =
		oaat_pkg::DIV_STEP_W'(oaat_pkg::HASH_W - 1);

	state_t                              state_q;
	logic [oaat_pkg::DIV_STEP_W-1:0]     step_q;
	oaat_pkg::hash_t                     dividend_q;
	oaat_pkg::hash_t                     hash_q;
	logic [oaat_pkg::COUNT_W-1:0]        rem_q;
	logic [oaat_pkg::COUNT_W:0]          trial;
	logic [oaat_pkg::COUNT_W:0]          diff;
	logic                                fits;

	always_comb begin
		trial = {rem_q, dividend_q[oaat_pkg::HASH_W-1]};
		diff  = trial - {1'b0, bucket_count};
		fits  = (trial >= {1'b0, bucket_count});
	end

	assign pop_ready    = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_DONE);
	assign full_hash    = hash_q;
	assign bucket_index = (bucket_count == '0) ? '0 : rem_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					dividend_q <= pop_data;
					hash_q     <= pop_data;
					rem_q      <= '0;
				end
			end
			ST_DIV: begin
				dividend_q <= dividend_q << 1;
				rem_q      <= fits ? diff[oaat_pkg::COUNT_W-1:0] : trial[oaat_pkg::COUNT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/one_at_a_time_bucket_hash.sv =====
// ----------------------------------------------------------------------------
// one_at_a_time_bucket_hash
// One-at-a-time key hash with a bucket select over a configurable table size.
//
//   Channel   Handshake         Payload
//   in        in_valid/ready    key_byte, last_byte
//   out       out_valid/ready   bucket_index, full_hash
//   config    APB write/read    bucket_count at addresses 0 to 3
//
// Bytes that are not the last stream in at one per cycle. After the last byte
// the front finalises the hash in ST_FIN1 and ST_FIN2 and then offers it to
// the queue in ST_PUSH, where it waits while the queue is full. The back
// divides bit-serially and takes no new hash until its result is taken; the
// queue lets the front absorb the next key meanwhile. Reset clears the running
// hash and sets bucket_count to 128.
// ----------------------------------------------------------------------------
module one_at_a_time_bucket_hash #(
	parameter int QUEUE_DEPTH = oaat_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [oaat_pkg::BYTE_W-1:0]       key_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [oaat_pkg::COUNT_W-1:0]      bucket_index,
	output logic [oaat_pkg::HASH_W-1:0]       full_hash,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [oaat_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [oaat_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [oaat_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	logic [oaat_pkg::COUNT_W-1:0] bucket_count_q;
	logic                         push_valid;
	logic                         push_ready;
	oaat_pkg::hash_t              push_data;
	logic                         pop_valid;
	logic                         pop_ready;
	oaat_pkg::hash_t              pop_data;
	logic                         reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[oaat_pkg::APB_ADDR_W-1] ==
		oaat_pkg::REG_BUCKET_COUNT[oaat_pkg::APB_ADDR_W-1]);
	assign prdata  = reg_hit ? bucket_count_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= oaat_pkg::BUCKET_COUNT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			bucket_count_q <= pwdata[oaat_pkg::COUNT_W-1:0];
		end
	end

	oaat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_byte   (key_byte),
		.last_byte  (last_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	oaat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	oaat_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.bucket_count (bucket_count_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index),
		.full_hash    (full_hash)
	);

endmodule

// ===== hw/rtl/oaat_checker.sv =====
// ----------------------------------------------------------------------------
// oaat_checker
// Port-level checks for the one-at-a-time bucket hash, bound to the top level.
// ----------------------------------------------------------------------------
module oaat_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              last_byte,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [oaat_pkg::COUNT_W-1:0]      bucket_index,
	input  logic [oaat_pkg::HASH_W-1:0]       full_hash,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [oaat_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [oaat_pkg::APB_DATA_W-1:0]   pwdata,
	input  logic [oaat_pkg::APB_DATA_W-1:0]   prdata,
	input  logic                              pready
);

	logic [oaat_pkg::COUNT_W-1:0] shadow_count_q;
	logic                         shadow_hit;

	assign shadow_hit = (paddr[oaat_pkg::APB_ADDR_W-1] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count_q <= oaat_pkg::BUCKET_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && shadow_hit) begin
			shadow_count_q <= pwdata[oaat_pkg::COUNT_W-1:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(full_hash) && $stable(bucket_index))
		else $error("Result changed while stalled.");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_byte |=> !in_ready)
		else $error("Input taken during finalisation.");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shadow_count_q != '0 |-> bucket_index < shadow_count_q)
		else $error("Bucket index not below bucket count.");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shadow_count_q == '0 |-> bucket_index == '0)
		else $error("Bucket index not zero for zero bucket count.");

	a_read_back: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && shadow_hit |-> prdata == shadow_count_q)
		else $error("Register read does not match the last write.");

endmodule

bind one_at_a_time_bucket_hash oaat_checker u_oaat_checker (.*);
